>>> sv/sspan_pkg.sv
package sspan_pkg;

  localparam int PRICE_W        = 32;
  localparam int SPAN_W         = 11;
  localparam int MAX_DAYS_DEF   = 1024;
  localparam int PRICE_BITS_DEF = 32;

  typedef struct packed {
    logic [PRICE_W-1:0] price;
    logic               series_start;
  } in_t;

  typedef struct packed {
    logic [SPAN_W-1:0] span;
    logic              overflow;
  } out_t;

  typedef struct packed {
    logic              pop;
    logic [SPAN_W-1:0] span;
  } alu_res_t;

endpackage

>>> sv/stock_span_stack_engine_core.sv
// Stock span engine.
// Request channel (req_valid/req_stall/req) takes one price per day and a
// series_start flag; result channel (res_valid/res_stall/res) returns that
// day's span and the sticky overflow flag, one result per request.
// A request is taken only while the sequencer is idle. It then scans the
// price stack one entry per cycle: each cycle reads the top entry from the
// stack RAM and compares it with today's price, popping while the top is
// not above it. The first entry above today (or an empty stack) ends the
// scan; today is pushed and the result is registered in the same cycle.
// Each day is pushed once and popped at most once. A series longer than
// MAX_DAYS days skips the scan from then on; span saturates at MAX_DAYS.
// The result register holds while res_stall is high; the next request may
// be taken then, but its scan waits at the end until the register is free.
// Reset (rst, synchronous) empties the stack and starts a new series; the
// stack RAM itself is not cleared, entries above the fill are never used.
module stock_span_stack_engine_core #(
  parameter int MAX_DAYS   = sspan_pkg::MAX_DAYS_DEF,
  parameter int PRICE_BITS = sspan_pkg::PRICE_BITS_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_stall,
  input  sspan_pkg::in_t  req,
  output logic            res_valid,
  input  logic            res_stall,
  output sspan_pkg::out_t res
);

  localparam int AW = $clog2(MAX_DAYS);
  localparam int DW = $clog2(MAX_DAYS + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_FLAG = 2'd2;

  logic [1:0]            state, state_next;
  logic [DW-1:0]         fill, fill_next;
  logic [DW-1:0]         day, day_next;
  logic                  ovf, ovf_next;
  logic [PRICE_BITS-1:0] cur_price;
  logic [PRICE_BITS-1:0] price_in;

  logic                  accept;
  logic                  room;
  logic [DW-1:0]         fill_eff;
  logic [DW-1:0]         day_eff;
  logic                  ovf_eff;
  logic [AW-1:0]         rd_addr;
  logic                  wr_en;
  logic [PRICE_BITS-1:0] top_price;
  logic [AW-1:0]         top_day;
  logic                  load;
  sspan_pkg::out_t       res_next;
  sspan_pkg::alu_res_t   alu;

  generate
    if (PRICE_BITS > sspan_pkg::PRICE_W) begin : g_wide
      assign price_in = {{(PRICE_BITS - sspan_pkg::PRICE_W){1'b0}}, req.price};
    end else if (PRICE_BITS == sspan_pkg::PRICE_W) begin : g_same
      assign price_in = req.price;
    end else begin : g_narrow
      assign price_in = req.price[PRICE_BITS-1:0];
    end
  endgenerate

  assign req_stall = (state != ST_IDLE);
  assign accept    = req_valid && !req_stall;
  assign room      = !res_valid || !res_stall;

  assign fill_eff = req.series_start ? '0 : fill;
  assign day_eff  = req.series_start ? '0 : day;
  assign ovf_eff  = req.series_start ? 1'b0 : ovf;

  sspan_stack #(
    .DEPTH (MAX_DAYS),
    .PW    (PRICE_BITS),
    .AW    (AW)
  ) u_stack (
    .clk      (clk),
    .we       (wr_en),
    .wr_addr  (fill[AW-1:0]),
    .wr_price (cur_price),
    .wr_day   (day[AW-1:0]),
    .rd_addr  (rd_addr),
    .rd_price (top_price),
    .rd_day   (top_day)
  );

  sspan_alu #(
    .PW (PRICE_BITS),
    .AW (AW),
    .DW (DW)
  ) u_alu (
    .empty     (fill == '0),
    .top_price (top_price),
    .top_day   (top_day),
    .cur_price (cur_price),
    .day       (day),
    .res       (alu)
  );

  always_comb begin
    state_next = state;
    fill_next  = fill;
    day_next   = day;
    ovf_next   = ovf;
    rd_addr    = AW'(fill - DW'(1));
    wr_en      = 1'b0;
    load       = 1'b0;
    res_next   = res;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          fill_next = fill_eff;
          day_next  = day_eff;
          ovf_next  = ovf_eff;
          rd_addr   = AW'(fill_eff - DW'(1));
          if (ovf_eff || (day_eff >= DW'(MAX_DAYS))) begin
            ovf_next   = 1'b1;
            state_next = ST_FLAG;
          end else begin
            state_next = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (alu.pop) begin
          fill_next = fill - DW'(1);
          rd_addr   = AW'(fill - DW'(2));
        end else if (room) begin
          wr_en             = 1'b1;
          fill_next         = fill + DW'(1);
          day_next          = day + DW'(1);
          load              = 1'b1;
          res_next.span     = alu.span;
          res_next.overflow = 1'b0;
          state_next        = ST_IDLE;
        end
      end
      ST_FLAG: begin
        if (room) begin
          load              = 1'b1;
          res_next.span     = sspan_pkg::SPAN_W'(MAX_DAYS);
          res_next.overflow = 1'b1;
          state_next        = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      fill      <= '0;
      day       <= '0;
      ovf       <= 1'b0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      day   <= day_next;
      ovf   <= ovf_next;
      if (load) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cur_price <= price_in;
    end
    if (load) begin
      res <= res_next;
    end
  end

endmodule

>>> sv/sspan_stack.sv
module sspan_stack #(
  parameter int DEPTH = sspan_pkg::MAX_DAYS_DEF,
  parameter int PW    = sspan_pkg::PRICE_BITS_DEF,
  parameter int AW    = $clog2(sspan_pkg::MAX_DAYS_DEF)
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] wr_addr,
  input  logic [PW-1:0] wr_price,
  input  logic [AW-1:0] wr_day,
  input  logic [AW-1:0] rd_addr,
  output logic [PW-1:0] rd_price,
  output logic [AW-1:0] rd_day
);

  logic [PW+AW-1:0] mem [DEPTH];
  logic [PW+AW-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= {wr_price, wr_day};
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

  assign rd_price = rd_data[PW+AW-1:AW];
  assign rd_day   = rd_data[AW-1:0];

endmodule

>>> sv/sspan_alu.sv
module sspan_alu #(
  parameter int PW = sspan_pkg::PRICE_BITS_DEF,
  parameter int AW = $clog2(sspan_pkg::MAX_DAYS_DEF),
  parameter int DW = $clog2(sspan_pkg::MAX_DAYS_DEF + 1)
) (
  input  logic                 empty,
  input  logic [PW-1:0]        top_price,
  input  logic [AW-1:0]        top_day,
  input  logic [PW-1:0]        cur_price,
  input  logic [DW-1:0]        day,
  output sspan_pkg::alu_res_t  res
);

  localparam int SW = (DW > sspan_pkg::SPAN_W) ? DW : sspan_pkg::SPAN_W;

  logic [SW-1:0] span_full;

  always_comb begin
    if (empty) begin
      span_full = SW'(day) + SW'(1);
    end else begin
      span_full = SW'(day) - SW'(top_day);
    end
    res.pop  = !empty && (top_price <= cur_price);
    res.span = span_full[sspan_pkg::SPAN_W-1:0];
  end

endmodule
